@@ rtl/positional_record_list_macros.svh @@
// assertion macros for the positional record list
`ifndef POSITIONAL_RECORD_LIST_MACROS_SVH
`define POSITIONAL_RECORD_LIST_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define PRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/prl_pkg.sv @@
`default_nettype none

package prl_pkg;

    // list geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int OP_W  = 3;
    localparam int POS_W = 11;
    localparam int KEY_W = 64;
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_FIND_NAME = 3'd2,
        OP_FIND_ID   = 3'd3,
        OP_COUNT     = 3'd4
    } t_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // one input item
    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] record_id;
        logic [KEY_W-1:0] record_name;
        logic [KEY_W-1:0] search_key;
    } t_item;

    // one result item
    typedef struct packed {
        logic             status;
        logic [POS_W-1:0] found_position;
        logic [KEY_W-1:0] found_id;
        logic [KEY_W-1:0] found_name;
        logic [POS_W-1:0] entry_count;
    } t_result;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0] id;
        logic [KEY_W-1:0] name;
    } t_rec;

endpackage

`default_nettype wire

@@ rtl/positional_record_list.sv @@
// report count and rejected items go straight from accept to the result strobe;
// insert and remove shift the entries between the position and the tail, search
// walks from the head and stops at the first hit
// one entry moved or compared per cycle; next item accepted in the cycle after the strobe
// reset: synchronous active-low, clears the count and the sequencer; list memory kept
// the result strobe lasts one cycle and the receiver cannot stall
`default_nettype none
`include "positional_record_list_macros.svh"

module positional_record_list
    import prl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_item   i_item,
    output logic         busy,
    output logic         o_valid,
    output t_result      o_result
);

    // record memory
    t_rec                 mem [CAPACITY];
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    t_rec                 mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;

    // registers
    t_state               r_state, n_state;
    logic [OP_W-1:0]      r_op, n_op;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [KEY_W-1:0]     r_key, n_key;
    t_rec                 r_new, n_new;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [ADDR_W-1:0]    r_rd_addr, n_rd_addr;
    logic [CNT_W-1:0]     r_rd_left, n_rd_left;
    logic                 r_pend, n_pend;
    logic [ADDR_W-1:0]    r_pend_addr, n_pend_addr;
    t_rec                 r_rdata;
    logic                 r_status, n_status;
    logic [POS_W-1:0]     r_fpos, n_fpos;
    logic [KEY_W-1:0]     r_fid, n_fid;
    logic [KEY_W-1:0]     r_fname, n_fname;

    // decode
    logic                 w_accept;
    logic [CMP_W-1:0]     w_cnt_x;
    logic [CMP_W-1:0]     w_pos_x;
    logic                 w_ins_ok;
    logic                 w_rem_ok;
    logic                 w_run_start;
    logic                 w_search;
    logic                 w_up;
    logic                 w_match;
    logic                 w_finish;
    logic [KEY_W-1:0]     w_cand;

    // item checks at accept
    always_comb begin
        w_accept = start && (r_state == ST_IDLE);
        w_cnt_x  = CMP_W'(r_count);
        w_pos_x  = CMP_W'(i_item.position);
        w_ins_ok = (w_cnt_x < CMP_W'(CAPACITY)) && (w_pos_x != '0)
                   && (w_pos_x <= w_cnt_x + CMP_W'(1));
        w_rem_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);
        case (i_item.operation)
            OP_INSERT:    w_run_start = w_ins_ok;
            OP_REMOVE:    w_run_start = w_rem_ok;
            OP_FIND_NAME: w_run_start = 1'b1;
            OP_FIND_ID:   w_run_start = 1'b1;
            default:      w_run_start = 1'b0;
        endcase
    end

    // walk control while running
    always_comb begin
        w_search = (r_op == OP_FIND_NAME) || (r_op == OP_FIND_ID);
        w_up     = (r_op != OP_INSERT);
        w_cand   = (r_op == OP_FIND_NAME) ? r_rdata.name : r_rdata.id;
        w_match  = r_pend && w_search && (w_cand == r_key);
        w_finish = (r_rd_left == '0) && !r_pend;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_run_start ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                if (w_match || w_finish) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op        = r_op;
        n_pos       = r_pos;
        n_key       = r_key;
        n_new       = r_new;
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_rd_left   = r_rd_left;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_status    = r_status;
        n_fpos      = r_fpos;
        n_fid       = r_fid;
        n_fname     = r_fname;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_rdata;
        mem_re      = 1'b0;
        mem_raddr   = r_rd_addr;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op         = i_item.operation;
                    n_pos        = i_item.position;
                    n_key        = i_item.search_key;
                    n_new.id     = i_item.record_id;
                    n_new.name   = i_item.record_name;
                    n_pend       = 1'b0;
                    n_status     = 1'b1;
                    n_fpos       = '0;
                    n_fid        = '0;
                    n_fname      = '0;
                    n_rd_left    = '0;
                    n_rd_addr    = '0;
                    case (i_item.operation)
                        OP_INSERT: begin
                            // shift entries position-1 .. count-1 up, top first
                            n_rd_left = CNT_W'(w_cnt_x - w_pos_x + CMP_W'(1));
                            n_rd_addr = ADDR_W'(w_cnt_x - CMP_W'(1));
                        end
                        OP_REMOVE: begin
                            // shift entries position .. count-1 down, bottom first
                            n_rd_left = CNT_W'(w_cnt_x - w_pos_x);
                            n_rd_addr = ADDR_W'(i_item.position);
                        end
                        OP_FIND_NAME, OP_FIND_ID: begin
                            n_rd_left = r_count;
                        end
                        OP_COUNT: begin
                            n_status = 1'b0;
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // data read last cycle: move it or compare it
                if (r_pend) begin
                    if (!w_search) begin
                        mem_we    = 1'b1;
                        mem_waddr = w_up ? (r_pend_addr - ADDR_W'(1))
                                         : (r_pend_addr + ADDR_W'(1));
                        mem_wdata = r_rdata;
                    end else if (w_match) begin
                        n_status = 1'b0;
                        n_fpos   = POS_W'(r_pend_addr) + POS_W'(1);
                        n_fid    = r_rdata.id;
                        n_fname  = r_rdata.name;
                    end
                end
                // issue the next read
                if ((r_rd_left != '0) && !w_match) begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_rd_addr;
                    n_rd_addr   = w_up ? (r_rd_addr + ADDR_W'(1)) : (r_rd_addr - ADDR_W'(1));
                    n_rd_left   = r_rd_left - CNT_W'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                end else begin
                    n_pend = 1'b0;
                end
                // walk complete: place new record and raise the count, or drop the count
                if (w_finish) begin
                    case (r_op)
                        OP_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(r_pos - POS_W'(1));
                            mem_wdata = r_new;
                            n_count   = r_count + CNT_W'(1);
                            n_status  = 1'b0;
                        end
                        OP_REMOVE: begin
                            n_count  = r_count - CNT_W'(1);
                            n_status = 1'b0;
                        end
                        default: begin
                            n_status = r_status;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                n_pend = 1'b0;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_key       <= n_key;
        r_new       <= n_new;
        r_rd_addr   <= n_rd_addr;
        r_rd_left   <= n_rd_left;
        r_pend_addr <= n_pend_addr;
        r_status    <= n_status;
        r_fpos      <= n_fpos;
        r_fid       <= n_fid;
        r_fname     <= n_fname;
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // outputs
    always_comb begin
        busy                    = (r_state != ST_IDLE);
        o_valid                 = (r_state == ST_DONE);
        o_result.status         = r_status;
        o_result.found_position = r_fpos;
        o_result.found_id       = r_fid;
        o_result.found_name     = r_fname;
        o_result.entry_count    = POS_W'(r_count);
    end

    // checks
    `PRL_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `PRL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `PRL_ASSERT_NEXT(a_strobe_once, o_valid, !busy && !o_valid, "result strobe not single")
    `PRL_ASSERT_NOW(a_pend_run, r_pend, r_state == ST_RUN, "read in flight outside the walk")

endmodule

`default_nettype wire

@@ tb/sv/positional_record_list_tb.sv @@
`default_nettype none

module positional_record_list_tb;
    import prl_pkg::*;

    logic    i_clk    = 1'b0;
    logic    i_rst_n  = 1'b0;
    logic    start    = 1'b0;
    t_item   drv_item = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    // items waiting to be sent, and results owed by the block
    t_item   cmd_queue[$];
    t_result expected_results[$];

    // shadow copy of the list, front of the queue is position 1
    t_rec    shadow_list[$];

    int      burst_left   = 0;
    int      gap_left     = 0;
    int      n_accepted   = 0;
    int      n_checked    = 0;
    int      n_rejected   = 0;
    int      peak_depth   = 0;
    int      mismatches   = 0;

    positional_record_list DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (drv_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // apply one item to the shadow list and return the result it should give
    function automatic t_result list_apply(input t_item it);
        t_result res;
        t_rec    rec;
        int      pos;
        int      depth;
        bit      hit;
        logic [KEY_W-1:0] probe;
        res        = '0;
        res.status = 1'b1;
        pos        = int'(it.position);
        depth      = shadow_list.size();
        hit        = 1'b0;
        case (it.operation)
            OP_INSERT: begin
                if (depth < CAPACITY && pos >= 1 && pos <= depth + 1) begin
                    rec.id   = it.record_id;
                    rec.name = it.record_name;
                    shadow_list.insert(pos - 1, rec);
                    res.status = 1'b0;
                end
            end
            OP_REMOVE: begin
                if (pos >= 1 && pos <= depth) begin
                    shadow_list.delete(pos - 1);
                    res.status = 1'b0;
                end
            end
            OP_FIND_NAME, OP_FIND_ID: begin
                // first match wins
                for (int i = 0; i < depth && !hit; i++) begin
                    probe = (it.operation == OP_FIND_NAME) ? shadow_list[i].name
                                                           : shadow_list[i].id;
                    if (probe == it.search_key) begin
                        hit                = 1'b1;
                        res.status         = 1'b0;
                        res.found_position = POS_W'(i + 1);
                        res.found_id       = shadow_list[i].id;
                        res.found_name     = shadow_list[i].name;
                    end
                end
            end
            OP_COUNT: begin
                res.status = 1'b0;
            end
            default: begin
            end
        endcase
        res.entry_count = POS_W'(shadow_list.size());
        if (shadow_list.size() > peak_depth) peak_depth = shadow_list.size();
        if (res.status) n_rejected++;
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.operation   = OP_W'($urandom);
        it.position    = POS_W'($urandom);
        it.record_id   = rand64();
        it.record_name = rand64();
        it.search_key  = rand64();
        return it;
    endfunction

    function automatic t_item mk(input logic [OP_W-1:0] op, input int pos,
                                 input logic [KEY_W-1:0] id, input logic [KEY_W-1:0] name,
                                 input logic [KEY_W-1:0] key);
        t_item it;
        it.operation   = op;
        it.position    = POS_W'(pos);
        it.record_id   = id;
        it.record_name = name;
        it.search_key  = key;
        return it;
    endfunction

    // mostly legal positions, some just past the end, some anywhere in 11 bits
    function automatic int pick_pos(input int limit);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 2047);
        if (r == 1) return limit + 1;
        return (limit >= 1) ? $urandom_range(1, limit) : 1;
    endfunction

    // key drawn from the list some of the time so that searches hit and names repeat
    function automatic logic [KEY_W-1:0] pick_key(input bit want_name, input int hit_pct);
        int   r;
        int   n;
        t_rec rec;
        r = $urandom_range(0, 99);
        n = shadow_list.size();
        if (r < hit_pct && n > 0) begin
            rec = shadow_list[$urandom_range(0, n - 1)];
            return want_name ? rec.name : rec.id;
        end
        case (r % 10)
            7:       return KEY_W'($urandom_range(0, 255));
            8:       return '1;
            9:       return '0;
            default: return rand64();
        endcase
    endfunction

    // block until everything sent has been answered
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || start || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // random batch built from the list as it stands now, depth kept moderate
    task automatic random_batch(input int n);
        int    est;
        int    k;
        int    sel;
        int    ins_w;
        int    rem_w;
        int    pos;
        t_item it;
        est = shadow_list.size();
        for (k = 0; k < n; k++) begin
            it    = random_item();
            ins_w = (est > 48) ? 15 : 38;
            rem_w = (est > 48) ? 45 : 22;
            sel   = $urandom_range(0, 99);
            if (sel < ins_w) begin
                pos            = pick_pos(est + 1);
                it.operation   = OP_INSERT;
                it.position    = POS_W'(pos);
                it.record_id   = pick_key(1'b0, 10);
                it.record_name = pick_key(1'b1, 10);
                if (pos >= 1 && pos <= est + 1) est++;
            end else if (sel < ins_w + rem_w) begin
                pos          = pick_pos(est);
                it.operation = OP_REMOVE;
                it.position  = POS_W'(pos);
                if (pos >= 1 && pos <= est) est--;
            end else if (sel < ins_w + rem_w + 14) begin
                it.operation  = OP_FIND_NAME;
                it.search_key = pick_key(1'b1, 65);
            end else if (sel < ins_w + rem_w + 28) begin
                it.operation  = OP_FIND_ID;
                it.search_key = pick_key(1'b0, 65);
            end else if (sel < ins_w + rem_w + 33) begin
                it.operation = OP_COUNT;
            end else begin
                it.operation = OP_W'($urandom_range(5, 7));
            end
            cmd_queue.push_back(it);
        end
    endtask

    // driver: hold start until accepted, bursts with random gaps in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            drv_item <= '0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(list_apply(drv_item));
                n_accepted++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0 || cmd_queue.size() == 0) begin
                    start    <= 1'b0;
                    drv_item <= random_item();
                    if (gap_left > 0) gap_left--;
                end else begin
                    start    <= 1'b1;
                    drv_item <= cmd_queue.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(20, 40);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 6);
                            gap_left   = $urandom_range(1, 12);
                        end
                    end
                end
            end
        end
    end

    function automatic void field_check(input string fname, input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", fname, want, got);
            mismatches++;
        end
    endfunction

    // monitor: every strobe is compared with the oldest outstanding item
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding: %p", o_result);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                field_check("status", KEY_W'(want.status), KEY_W'(o_result.status));
                field_check("found_position", KEY_W'(want.found_position),
                            KEY_W'(o_result.found_position));
                field_check("found_id", want.found_id, o_result.found_id);
                field_check("found_name", want.found_name, o_result.found_name);
                field_check("entry_count", KEY_W'(want.entry_count),
                            KEY_W'(o_result.entry_count));
            end
        end
    end

    // stimulus
    initial begin
        logic [KEY_W-1:0] id_c;
        logic [KEY_W-1:0] id_d;
        int               k;
        int               n;
        int               done_random;

        id_c = 64'h0123_4567_89ab_cdef;
        id_d = 64'h0000_0000_0000_1d1d;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list, edge positions, duplicates, unknown codes
        cmd_queue.push_back(mk(OP_COUNT, 0, '0, '0, '0));
        cmd_queue.push_back(mk(OP_FIND_NAME, 0, '0, '0, '0));
        cmd_queue.push_back(mk(OP_FIND_ID, 0, '0, '0, '1));
        cmd_queue.push_back(mk(OP_REMOVE, 1, '0, '0, '0));
        cmd_queue.push_back(mk(OP_INSERT, 0, '1, '1, '0));
        cmd_queue.push_back(mk(OP_INSERT, 2, '1, '1, '0));
        cmd_queue.push_back(mk(OP_INSERT, 1, '0, '0, '1));
        cmd_queue.push_back(mk(OP_INSERT, 1, '1, '1, '0));
        cmd_queue.push_back(mk(OP_INSERT, 3, id_c, 64'("alpha"), '0));
        cmd_queue.push_back(mk(OP_INSERT, 2, id_d, 64'("alpha"), '0));
        cmd_queue.push_back(mk(OP_FIND_NAME, 0, '0, '0, 64'("alpha")));
        cmd_queue.push_back(mk(OP_FIND_ID, 0, '0, '0, id_c));
        cmd_queue.push_back(mk(OP_FIND_ID, 0, '1, '1, '0));
        cmd_queue.push_back(mk(OP_FIND_NAME, 0, '0, '0, '1));
        cmd_queue.push_back(mk(OP_FIND_NAME, 2047, '0, '0, 64'("omega")));
        cmd_queue.push_back(mk(OP_REMOVE, 0, '0, '0, '0));
        cmd_queue.push_back(mk(OP_REMOVE, 5, '0, '0, '0));
        cmd_queue.push_back(mk(OP_REMOVE, 2047, '1, '1, '1));
        cmd_queue.push_back(mk(OP_INSERT, 2047, '1, '1, '1));
        cmd_queue.push_back(mk(OP_INSERT, 6, rand64(), rand64(), '0));
        for (k = 5; k <= 7; k++)
            cmd_queue.push_back(mk(OP_W'(k), 1, rand64(), rand64(), rand64()));
        cmd_queue.push_back(mk(OP_REMOVE, 2, '0, '0, '0));
        cmd_queue.push_back(mk(OP_REMOVE, 3, '0, '0, '0));
        cmd_queue.push_back(mk(OP_COUNT, 1, '1, '1, '1));
        wait_idle();

        // random traffic in batches, each drained before the next is built
        done_random = 0;
        while (done_random < 555) begin
            n = $urandom_range(8, 40);
            random_batch(n);
            done_random += n;
            wait_idle();
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        $display("summary: %0d items accepted, %0d results checked, %0d rejected or not found",
                 n_accepted, n_checked, n_rejected);
        $display("summary: list depth reached %0d of %0d entries", peak_depth, CAPACITY);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

@@ positional_record_list.f @@
+incdir+rtl
rtl/prl_pkg.sv
rtl/positional_record_list.sv
tb/sv/positional_record_list_tb.sv
